/* rtl/uvs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types and constants of the UV sphere vertex generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

    typedef logic signed [15:0] q14_t;

    localparam logic [15:0] Q14_ONE = 16'd16384;

    typedef enum logic [2:0] {
        REG_RADIUS       = 3'd0,
        REG_WIDTH_SEGS   = 3'd1,
        REG_HEIGHT_SEGS  = 3'd2,
        REG_PHI_START    = 3'd3,
        REG_PHI_LENGTH   = 3'd4,
        REG_THETA_START  = 3'd5,
        REG_THETA_LENGTH = 3'd6
    } cfg_reg_t;

endpackage
`default_nettype wire

/* rtl/uvs_sine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_sine
// Pipelined sine of a turn-fraction angle, Q1.14 result, eight stages.
// ----------------------------------------------------------------------------
module uvs_sine #(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic [ANGLE_BITS-1:0] angle,
    output uvs_pkg::q14_t              result
);
    import uvs_pkg::*;

    localparam logic [30:0] SIN_C1 = 31'd1686629713;
    localparam logic [30:0] SIN_C3 = 31'd693598668;
    localparam logic [30:0] SIN_C5 = 31'd85569306;
    localparam logic [30:0] SIN_C7 = 31'd5026995;
    localparam logic [30:0] SIN_C9 = 31'd172272;
    localparam logic [30:0] Q30_ONE = 31'h40000000;

    logic [1:0]  quad;
    logic [29:0] frac;
    logic [30:0] t_next;

    logic [30:0] t_reg   [0:5];
    logic [30:0] t2_reg  [0:3];
    logic [30:0] acc_reg [0:3];
    logic        neg_reg [0:6];
    logic [30:0] s_reg;
    q14_t        res_reg;

    logic [61:0] p_t2, p_a7, p_a5, p_a3, p_a1, p_s;
    logic [31:0] s_round;
    logic [15:0] q_mag, q_clamp;

    assign quad = angle[ANGLE_BITS-1:ANGLE_BITS-2];
    assign frac = 30'({angle[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}});
    assign t_next = quad[0] ? (Q30_ONE - {1'b0, frac}) : {1'b0, frac};

    assign p_t2 = 62'(t_reg[0]) * 62'(t_reg[0]);
    assign p_a7 = 62'(t2_reg[0]) * 62'(SIN_C9);
    assign p_a5 = 62'(t2_reg[1]) * 62'(acc_reg[0]);
    assign p_a3 = 62'(t2_reg[2]) * 62'(acc_reg[1]);
    assign p_a1 = 62'(t2_reg[3]) * 62'(acc_reg[2]);
    assign p_s  = 62'(t_reg[5]) * 62'(acc_reg[3]);

    assign s_round = 32'(s_reg) + 32'd32768;
    assign q_mag   = s_round[31:16];
    assign q_clamp = (q_mag > Q14_ONE) ? Q14_ONE : q_mag;

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg[0]   <= t_next;
            neg_reg[0] <= quad[1];
            for (int i = 1; i < 6; i++) begin
                t_reg[i] <= t_reg[i-1];
            end
            for (int i = 1; i < 7; i++) begin
                neg_reg[i] <= neg_reg[i-1];
            end
            t2_reg[0] <= p_t2[60:30];
            for (int i = 1; i < 4; i++) begin
                t2_reg[i] <= t2_reg[i-1];
            end
            acc_reg[0] <= SIN_C7 - p_a7[60:30];
            acc_reg[1] <= SIN_C5 - p_a5[60:30];
            acc_reg[2] <= SIN_C3 - p_a3[60:30];
            acc_reg[3] <= SIN_C1 - p_a1[60:30];
            s_reg      <= p_s[60:30];
            res_reg    <= neg_reg[6] ? -q14_t'(q_clamp) : q14_t'(q_clamp);
        end
    end

    assign result = res_reg;

endmodule
`default_nettype wire

/* rtl/uv_sphere_vertex_generator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Vertex position, normal, tangent, texture coordinates and index of one
// grid point of a latitude-longitude sphere.
// ----------------------------------------------------------------------------
// Takes one grid point (col, row) per clock while the result is not stalled;
// a stalled result holds the whole pipeline. The pipeline is made of
// the input register and the divider set-up stage, the rounding dividers (six
// stages of three quotient bits each), the sine polynomial (eight stages, six
// of them multiplying), two product stages and the output register.
// The user must write configuration through the cfg port only while no point
// is in flight; the block does not enforce this. A write takes effect at once.
module uv_sphere_vertex_generator #(
    parameter int MAX_SEGMENTS = 255,
    parameter int ANGLE_BITS   = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,   // col[7:0], row[15:8]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pos_x[16:0], pos_y[33:17], pos_z[50:34], norm_x[66:51], norm_y[82:67],
    // norm_z[98:83], tan_x[114:99], tan_z[130:115], tex_u[147:131],
    // tex_v[164:148], vertex_number[180:165]
    output logic [183:0]      m_tdata,
    output logic [0:0]        m_tuser,   // tan_valid[0]
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [16:0]  cfg_data
);
    import uvs_pkg::*;

    localparam int NVLD = 18;
    localparam int NDIV = 6;
    localparam int NSIDE = 10;
    localparam logic [7:0] SEG_MAX = 8'(MAX_SEGMENTS);
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    typedef struct packed {
        logic [9:0]  rem;
        logic [17:0] nq;
    } div_t;

    typedef struct packed {
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic [15:0] vn;
    } side_t;

    function automatic div_t div_iter(div_t a, logic [9:0] dv);
        logic [9:0] rm;
        div_t       b;
        rm   = {a.rem[8:0], a.nq[17]};
        b.nq = {a.nq[16:0], 1'b0};
        if (rm >= dv) begin
            rm      = rm - dv;
            b.nq[0] = 1'b1;
        end
        b.rem = rm;
        return b;
    endfunction

    function automatic div_t div_init(logic [25:0] n);
        div_t d;
        d.rem = {2'b00, n[25:18]};
        d.nq  = n[17:0];
        return d;
    endfunction

    function automatic logic [7:0] clamp_seg(logic [7:0] s);
        if (s == 8'd0) begin
            return 8'd1;
        end
        if (s > SEG_MAX) begin
            return SEG_MAX;
        end
        return s;
    endfunction

    logic [15:0] radius_reg;
    logic [7:0]  wseg_reg, hseg_reg;
    logic [15:0] phi_start_reg, theta_start_reg, theta_length_reg;
    logic [16:0] phi_length_reg;

    logic        adv;
    logic        vld_reg [0:NVLD-1];
    logic        m_tvalid_reg;

    logic [7:0]  w_eff, h_eff, col_in, row_in;
    logic [9:0]  dv_w, dv_h;

    logic [7:0]  c_reg, r_reg;
    div_t        div_reg [0:NDIV][0:3];
    div_t        div_next [1:NDIV][0:3];
    logic [15:0] vn_reg  [0:NDIV];
    side_t       side_reg [0:NSIDE-1];

    logic [25:0] n_phi, n_th, n_u, n_v;
    logic [16:0] q_phi, q_th, q_u, q_v;
    logic [ANGLE_BITS-1:0] phi_ang, theta_ang, phi_cos_ang, theta_cos_ang;
    q14_t        sp, cp, st, ct;

    logic signed [31:0] pcs, pss;
    logic [28:0] pcs_mag_reg, pss_mag_reg;
    logic        pcs_neg_reg, pss_neg_reg, ct_neg_reg;
    logic [14:0] ct_mag_reg;
    q14_t        ct1_reg, tx1_reg, tz1_reg;
    logic        tv1_reg;

    logic [44:0] pxm_reg, pzm_reg;
    logic [30:0] pym_reg;
    logic        px_neg_reg, pz_neg_reg, py_neg_reg;
    q14_t        nx2_reg, ny2_reg, nz2_reg, tx2_reg, tz2_reg;
    logic        tv2_reg;
    logic [29:0] ncs_round, nss_round;

    logic [45:0] pxr, pzr;
    logic [31:0] pyr;

    logic signed [16:0] pos_x_reg, pos_y_reg, pos_z_reg;
    q14_t        norm_x_reg, norm_y_reg, norm_z_reg, tan_x_reg, tan_z_reg;
    logic        tan_valid_reg;
    side_t       out_side_reg;

    assign adv       = !m_tvalid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg       <= 16'd256;
            wseg_reg         <= 8'd16;
            hseg_reg         <= 8'd16;
            phi_start_reg    <= 16'd0;
            phi_length_reg   <= 17'd65536;
            theta_start_reg  <= 16'd0;
            theta_length_reg <= 16'd32768;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_addr))
                REG_RADIUS:       radius_reg       <= cfg_data[15:0];
                REG_WIDTH_SEGS:   wseg_reg         <= cfg_data[7:0];
                REG_HEIGHT_SEGS:  hseg_reg         <= cfg_data[7:0];
                REG_PHI_START:    phi_start_reg    <= cfg_data[15:0];
                REG_PHI_LENGTH:   phi_length_reg   <= cfg_data;
                REG_THETA_START:  theta_start_reg  <= cfg_data[15:0];
                REG_THETA_LENGTH: theta_length_reg <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign w_eff  = clamp_seg(wseg_reg);
    assign h_eff  = clamp_seg(hseg_reg);
    assign dv_w   = {1'b0, w_eff, 1'b0};
    assign dv_h   = {1'b0, h_eff, 1'b0};
    assign col_in = s_tdata[7:0];
    assign row_in = s_tdata[15:8];

    assign n_phi = {25'(c_reg) * 25'(phi_length_reg), 1'b0} + 26'(w_eff);
    assign n_th  = {25'(r_reg) * 25'(theta_length_reg), 1'b0} + 26'(h_eff);
    assign n_u   = {1'b0, c_reg, 17'd0} + 26'(w_eff);
    assign n_v   = {1'b0, r_reg, 17'd0} + 26'(h_eff);

    always_comb begin
        for (int s = 1; s <= NDIV; s++) begin
            for (int l = 0; l < 4; l++) begin
                div_next[s][l] = div_reg[s-1][l];
                for (int k = 0; k < 3; k++) begin
                    div_next[s][l] = div_iter(div_next[s][l], l[0] ? dv_h : dv_w);
                end
            end
        end
    end

    assign q_phi = div_reg[NDIV][0].nq[16:0];
    assign q_th  = div_reg[NDIV][1].nq[16:0];
    assign q_u   = div_reg[NDIV][2].nq[16:0];
    assign q_v   = div_reg[NDIV][3].nq[16:0];

    assign phi_ang       = ANGLE_BITS'(32'(phi_start_reg) + 32'(q_phi));
    assign theta_ang     = ANGLE_BITS'(32'(theta_start_reg) + 32'(q_th));
    assign phi_cos_ang   = phi_ang + QUARTER;
    assign theta_cos_ang = theta_ang + QUARTER;

    uvs_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_phi (
        .aclk(aclk), .en(adv), .angle(phi_ang), .result(sp)
    );
    uvs_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_phi (
        .aclk(aclk), .en(adv), .angle(phi_cos_ang), .result(cp)
    );
    uvs_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_theta (
        .aclk(aclk), .en(adv), .angle(theta_ang), .result(st)
    );
    uvs_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_theta (
        .aclk(aclk), .en(adv), .angle(theta_cos_ang), .result(ct)
    );

    assign pcs = 32'(cp) * 32'(st);
    assign pss = 32'(sp) * 32'(st);

    assign ncs_round = 30'(pcs_mag_reg) + 30'd8192;
    assign nss_round = 30'(pss_mag_reg) + 30'd8192;

    assign pxr = 46'(pxm_reg) + 46'h8000000;
    assign pzr = 46'(pzm_reg) + 46'h8000000;
    assign pyr = 32'(pym_reg) + 32'd8192;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NVLD; i++) begin
                vld_reg[i] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < NVLD; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            m_tvalid_reg <= vld_reg[NVLD-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_reg <= (col_in > w_eff) ? w_eff : col_in;
            r_reg <= (row_in > h_eff) ? h_eff : row_in;

            div_reg[0][0] <= div_init(n_phi);
            div_reg[0][1] <= div_init(n_th);
            div_reg[0][2] <= div_init(n_u);
            div_reg[0][3] <= div_init(n_v);
            vn_reg[0] <= 16'(16'(r_reg) * (16'(w_eff) + 16'd1) + 16'(c_reg));
            for (int s = 1; s <= NDIV; s++) begin
                for (int l = 0; l < 4; l++) begin
                    div_reg[s][l] <= div_next[s][l];
                end
                vn_reg[s] <= vn_reg[s-1];
            end

            side_reg[0].tex_u <= q_u;
            side_reg[0].tex_v <= 17'(18'd65536 - 18'(q_v));
            side_reg[0].vn    <= vn_reg[NDIV];
            for (int i = 1; i < NSIDE; i++) begin
                side_reg[i] <= side_reg[i-1];
            end

            pcs_neg_reg <= pcs[31];
            pss_neg_reg <= pss[31];
            pcs_mag_reg <= pcs[31] ? 29'(-pcs) : pcs[28:0];
            pss_mag_reg <= pss[31] ? 29'(-pss) : pss[28:0];
            ct_neg_reg  <= ct[15];
            ct_mag_reg  <= ct[15] ? 15'(-ct) : ct[14:0];
            ct1_reg     <= ct;
            tv1_reg     <= (st != 16'sd0);
            if (st == 16'sd0) begin
                tx1_reg <= 16'sd0;
                tz1_reg <= 16'sd0;
            end else begin
                tx1_reg <= st[15] ? -sp : sp;
                tz1_reg <= st[15] ? -cp : cp;
            end

            pxm_reg    <= 45'(radius_reg) * 45'(pcs_mag_reg);
            pzm_reg    <= 45'(radius_reg) * 45'(pss_mag_reg);
            pym_reg    <= 31'(radius_reg) * 31'(ct_mag_reg);
            px_neg_reg <= pcs_neg_reg;
            pz_neg_reg <= pss_neg_reg;
            py_neg_reg <= ct_neg_reg;
            nx2_reg    <= pcs_neg_reg ? q14_t'(ncs_round[29:14]) : -q14_t'(ncs_round[29:14]);
            nz2_reg    <= pss_neg_reg ? -q14_t'(nss_round[29:14]) : q14_t'(nss_round[29:14]);
            ny2_reg    <= ct1_reg;
            tx2_reg    <= tx1_reg;
            tz2_reg    <= tz1_reg;
            tv2_reg    <= tv1_reg;

            pos_x_reg     <= px_neg_reg ? $signed(pxr[44:28]) : -$signed(pxr[44:28]);
            pos_z_reg     <= pz_neg_reg ? -$signed(pzr[44:28]) : $signed(pzr[44:28]);
            pos_y_reg     <= py_neg_reg ? -$signed(pyr[30:14]) : $signed(pyr[30:14]);
            norm_x_reg    <= nx2_reg;
            norm_y_reg    <= ny2_reg;
            norm_z_reg    <= nz2_reg;
            tan_x_reg     <= tx2_reg;
            tan_z_reg     <= tz2_reg;
            tan_valid_reg <= tv2_reg;
            out_side_reg  <= side_reg[NSIDE-1];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = tan_valid_reg;
    assign m_tdata  = {3'b000, out_side_reg.vn, out_side_reg.tex_v, out_side_reg.tex_u,
                       tan_z_reg, tan_x_reg, norm_z_reg, norm_y_reg, norm_x_reg,
                       pos_z_reg, pos_y_reg, pos_x_reg};

`ifndef SYNTHESIS
    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result stalled");
    a_last_stage_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && vld_reg[NVLD-1]) |=> m_tvalid)
        else $error("pipeline item lost before output");
    a_pole_tangent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (tan_x_reg == 16'sd0 && tan_z_reg == 16'sd0))
        else $error("tangent nonzero at pole");
    a_tex_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_side_reg.tex_u <= 17'd65536 && out_side_reg.tex_v <= 17'd65536))
        else $error("texture coordinate out of range");
`endif

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere vertex generator testbench
// Streams grid points through the block under random source and sink gaps,
// predicts every vertex in fixed point and checks each result field by field.
// Runs through several sphere settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb;
    import uvs_pkg::*;

    typedef struct {
        logic signed [16:0] pos_x, pos_y, pos_z;
        logic signed [15:0] norm_x, norm_y, norm_z, tan_x, tan_z;
        logic               tan_valid;
        logic [16:0]        tex_u, tex_v;
        logic [15:0]        vertex_number;
    } vertex_t;

    class vertex_scoreboard;
        logic [15:0] radius_q88;
        logic [7:0]  segs_w, segs_h;
        logic [15:0] phi_base, theta_base;
        logic [16:0] phi_span;
        logic [15:0] theta_span;
        vertex_t     pending[$];
        int          errors;

        function new();
            radius_q88 = 256; segs_w = 16; segs_h = 16;
            phi_base = 0; phi_span = 17'd65536; theta_base = 0; theta_span = 16'd32768;
            errors = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [16:0] val);
            case (idx)
                REG_RADIUS:       radius_q88 = val[15:0];
                REG_WIDTH_SEGS:   segs_w     = val[7:0];
                REG_HEIGHT_SEGS:  segs_h     = val[7:0];
                REG_PHI_START:    phi_base   = val[15:0];
                REG_PHI_LENGTH:   phi_span   = val;
                REG_THETA_START:  theta_base = val[15:0];
                REG_THETA_LENGTH: theta_span = val[15:0];
                default: ;
            endcase
        endfunction

        function longint quarter_wave(longint t);
            longint t2, acc, s, q;
            t2 = (t * t) >>> 30;
            acc = 172272;
            acc = 5026995 - ((t2 * acc) >>> 30);
            acc = 85569306 - ((t2 * acc) >>> 30);
            acc = 693598668 - ((t2 * acc) >>> 30);
            acc = 1686629713 - ((t2 * acc) >>> 30);
            s = (t * acc) >>> 30;
            q = (s + 32768) >>> 16;
            return (q > 16384) ? 16384 : q;
        endfunction

        function longint sine_of(logic [31:0] ang);
            logic [31:0] x;
            longint f, m;
            x = {ang[15:0], 16'd0};
            f = longint'(x[29:0]);
            m = quarter_wave(x[30] ? (longint'(1) << 30) - f : f);
            return x[31] ? -m : m;
        endfunction

        function longint scaled_round(longint a, longint b, int sh);
            longint ma, mb, m;
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            m = (ma * mb + (longint'(1) << (sh - 1))) >>> sh;
            return ((a < 0) != (b < 0)) ? -m : m;
        endfunction

        function longint share(longint n, longint len, longint d);
            return (2 * n * len + d) / (2 * d);
        endfunction

        function void note_point(logic [7:0] col, logic [7:0] row);
            vertex_t v;
            longint w, h, c, r, sp, cp, st, ct;
            logic [31:0] phi, theta;
            w = (segs_w == 0) ? 1 : longint'(segs_w);
            h = (segs_h == 0) ? 1 : longint'(segs_h);
            c = (col > w) ? w : longint'(col);
            r = (row > h) ? h : longint'(row);
            phi = 32'(longint'(phi_base) + share(c, longint'(phi_span), w));
            theta = 32'(longint'(theta_base) + share(r, longint'(theta_span), h));
            sp = sine_of(phi);
            cp = sine_of(phi + 32'd16384);
            st = sine_of(theta);
            ct = sine_of(theta + 32'd16384);
            v.pos_x = 17'(-scaled_round(longint'(radius_q88), cp * st, 28));
            v.pos_y = 17'(scaled_round(longint'(radius_q88), ct, 14));
            v.pos_z = 17'(scaled_round(longint'(radius_q88), sp * st, 28));
            v.norm_x = 16'(-scaled_round(cp, st, 14));
            v.norm_y = 16'(ct);
            v.norm_z = 16'(scaled_round(sp, st, 14));
            v.tan_valid = (st != 0);
            v.tan_x = 16'((st == 0) ? 0 : (st < 0) ? -sp : sp);
            v.tan_z = 16'((st == 0) ? 0 : (st < 0) ? -cp : cp);
            v.tex_u = 17'(share(c, 65536, w));
            v.tex_v = 17'(65536 - share(r, 65536, h));
            v.vertex_number = 16'(r * (w + 1) + c);
            pending.push_back(v);
        endfunction

        function void compare(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_vertex(logic [183:0] d, logic tv);
            vertex_t e;
            if (pending.size() == 0) begin
                $error("vertex_result: expected none, actual %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            compare("pos_x", e.pos_x, $signed(d[16:0]));
            compare("pos_y", e.pos_y, $signed(d[33:17]));
            compare("pos_z", e.pos_z, $signed(d[50:34]));
            compare("norm_x", e.norm_x, $signed(d[66:51]));
            compare("norm_y", e.norm_y, $signed(d[82:67]));
            compare("norm_z", e.norm_z, $signed(d[98:83]));
            compare("tan_x", e.tan_x, $signed(d[114:99]));
            compare("tan_z", e.tan_z, $signed(d[130:115]));
            compare("tan_valid", e.tan_valid, tv);
            compare("tex_u", e.tex_u, d[147:131]);
            compare("tex_v", e.tex_v, d[164:148]);
            compare("vertex_number", e.vertex_number, d[180:165]);
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [15:0]  s_tdata = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [183:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [2:0]   cfg_addr = 0;
    logic [16:0]  cfg_data = 0;

    vertex_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  no_gaps = 0;
    bit  sink_hold = 0;

    uv_sphere_vertex_generator i_dut (.*);

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_point(s_tdata[7:0], s_tdata[15:8]);
        if (aresetn && m_tvalid && m_tready) sb.check_vertex(m_tdata, m_tuser[0]);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > 20000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (sink_hold) begin
                m_tready <= 0;
            end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 12);
                m_tready <= 0;
                repeat (gap) @(negedge aclk);
                m_tready <= 1;
            end else begin
                m_tready <= 1;
            end
        end
    end

    task automatic send_point(logic [7:0] col, logic [7:0] row);
        int gap;
        if (!no_gaps && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {row, col};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [16:0] val);
        cfg_valid <= 1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic load_sphere(logic [15:0] rad, logic [7:0] w, logic [7:0] h,
                               logic [15:0] ps, logic [16:0] pl,
                               logic [15:0] ts, logic [15:0] tl);
        write_reg(REG_RADIUS, 17'(rad));
        write_reg(REG_WIDTH_SEGS, 17'(w));
        write_reg(REG_HEIGHT_SEGS, 17'(h));
        write_reg(REG_PHI_START, 17'(ps));
        write_reg(REG_PHI_LENGTH, pl);
        write_reg(REG_THETA_START, 17'(ts));
        write_reg(REG_THETA_LENGTH, 17'(tl));
        cfg_valid <= 0;
    endtask

    task automatic random_points(int n, int wmax, int hmax);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0)
                send_point(8'($urandom), 8'($urandom));
            else
                send_point(8'($urandom_range(0, wmax + 1)), 8'($urandom_range(0, hmax + 1)));
        end
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // reset settings, grid corners, poles, out of range points
        send_point(0, 0);
        send_point(16, 16);
        send_point(8, 8);
        send_point(255, 255);
        send_point(255, 0);
        send_point(0, 255);
        send_point(4, 8);
        send_point(12, 3);
        send_point(8'haa, 8'h55);
        send_point(8'h55, 8'haa);
        drain();

        // zero segments used as one, zero radius
        load_sphere(0, 0, 0, 16'h1234, 17'd40000, 16'd1000, 16'd20000);
        send_point(0, 0);
        send_point(1, 1);
        send_point(200, 3);
        drain();

        // maximum radius and segments, wrapping angles
        load_sphere(16'hffff, 255, 255, 16'hffff, 17'h1ffff, 16'hffff, 16'hffff);
        send_point(255, 255);
        send_point(0, 0);
        send_point(128, 64);
        send_point(1, 254);
        drain();

        load_sphere(16'd300, 7, 5, 16'd0, 17'd65536, 16'd0, 16'd32768);
        random_points(250, 7, 5);
        drain();

        // hold the sink off while points pile up
        sink_hold = 1;
        fork
            random_points(60, 7, 5);
            begin
                repeat (150) @(negedge aclk);
                sink_hold = 0;
            end
        join
        drain();

        load_sphere(16'($urandom), 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                    16'($urandom), 17'($urandom_range(0, 65536)), 16'($urandom),
                    16'($urandom));
        random_points(250, 255, 255);
        drain();

        load_sphere(16'd1, 1, 255, 16'd0, 17'd0, 16'd32768, 16'd0);
        random_points(40, 1, 255);
        drain();

        load_sphere(16'($urandom), 8'($urandom_range(1, 40)), 8'($urandom_range(1, 40)),
                    16'($urandom), 17'($urandom_range(0, 65536)),
                    16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)));
        random_points(200, 40, 40);
        no_gaps = 1;
        random_points(100, 40, 40);
        drain();

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
